// File: rtl/core/mfc_pkg.sv
// shared types, constants and activation table builder for the perceptron classifier
// no dependencies
package mfc_pkg;

  localparam int MAX_LAYERS   = 4;
  localparam int MAX_WIDTH    = 16;
  localparam int WEIGHT_DEPTH = 2048;
  localparam int TABLE_SIZE   = 256;
  localparam int WADDR_W      = $clog2(WEIGHT_DEPTH);
  localparam int VIDX_W       = $clog2(MAX_WIDTH + 1);
  localparam int TIDX_W       = $clog2(TABLE_SIZE);
  localparam int LAYER_W      = $clog2(MAX_LAYERS);
  localparam int ACC_W        = 40;

  localparam logic REQ_WEIGHT = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [1:0] ACT_LOGISTIC = 2'd0;
  localparam logic [1:0] ACT_TANH     = 2'd1;

  localparam logic [2:0] REG_INPUT_COUNT = 3'd0;
  localparam logic [2:0] REG_LAYER_COUNT = 3'd1;
  localparam logic [2:0] REG_SIZE_1      = 3'd2;
  localparam logic [2:0] REG_SIZE_2      = 3'd3;
  localparam logic [2:0] REG_SIZE_3      = 3'd4;
  localparam logic [2:0] REG_SIZE_4      = 3'd5;
  localparam logic [2:0] REG_ACT_MODE    = 3'd6;

  localparam logic signed [15:0] BIAS_NEG_ONE = -16'sd256;

  typedef struct packed {
    logic              req_type;
    logic [10:0]       position;
    logic signed [15:0] data_value;
    logic              final_element;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]         neuron_index;
    logic signed [15:0] neuron_value;
    logic [3:0]         best_class;
    logic               last_output;
  } out_beat_t;

  typedef struct packed {
    logic [4:0] input_count;
    logic [2:0] layer_count;
    logic [4:0] size_1;
    logic [4:0] size_2;
    logic [4:0] size_3;
    logic [4:0] size_4;
    logic [1:0] act_mode;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic               wbank;
    logic [VIDX_W-1:0]  widx;
    logic signed [15:0] wdata;
    logic               rbank;
    logic [VIDX_W-1:0]  ridx;
  } vmem_req_t;

  typedef logic signed [15:0] tab_t [TABLE_SIZE];

  function automatic logic [4:0] clamp_size(logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'(MAX_WIDTH)) return 5'(MAX_WIDTH);
    return v;
  endfunction

  // restoring long division, truncating
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tab_t build_tab(logic tanh_form);
    tab_t              t;
    longint            n;
    longint unsigned   an, c, e, term, d, th, lg;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      n = 2 * longint'(i) + 1 - TABLE_SIZE;
      an = longint'(n < 0 ? -n : n);
      c = an * 8;
      e = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int k = 1; k < 200; k++) begin
        if (term != 0) begin
          term = udiv(term * c, longint'(k) * TABLE_SIZE);
          e = e + term;
        end
      end
      d = e + (64'd1 << 32);
      th = udiv((e - (64'd1 << 32)) * 256 + (d >> 1), d);
      if (n < 0) begin
        lg = udiv((64'd1 << 40) + (d >> 1), d);
        t[i] = tanh_form ? -16'(th) : 16'(lg);
      end else begin
        lg = udiv(e * 256 + (d >> 1), d);
        t[i] = tanh_form ? 16'(th) : 16'(lg);
      end
    end
    return t;
  endfunction

endpackage

// File: rtl/core/mlp_forward_classifier_top.sv
// A sample computes layer by layer: each layer starts by writing its bias, and each neuron then
// issues its weights, drains the multiply-accumulate pipe and is finalized, since the single
// multiplier takes one weight per cycle from the weight memory's read port; the outputs are
// then read out one at a time.
// Weight and sample beats are taken one per cycle while the engine is idle; stall is high from the final sample
// element until the last result has been loaded into the output register.
// depends on mfc_pkg, mfc_wmem, mfc_engine
module mlp_forward_classifier_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mfc_pkg::in_beat_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mfc_pkg::out_beat_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [4:0]           cfg_data
);

  mfc_pkg::cfg_t cfg;
  logic          in_fire;
  logic          busy;
  logic [mfc_pkg::WADDR_W-1:0] w_raddr;
  logic signed [15:0]          w_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_count <= 5'd1;
      cfg.layer_count <= 3'd1;
      cfg.size_1      <= 5'd1;
      cfg.size_2      <= 5'd1;
      cfg.size_3      <= 5'd1;
      cfg.size_4      <= 5'd1;
      cfg.act_mode    <= mfc_pkg::ACT_LOGISTIC;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mfc_pkg::REG_INPUT_COUNT: cfg.input_count <= cfg_data;
        mfc_pkg::REG_LAYER_COUNT: cfg.layer_count <= cfg_data[2:0];
        mfc_pkg::REG_SIZE_1:      cfg.size_1      <= cfg_data;
        mfc_pkg::REG_SIZE_2:      cfg.size_2      <= cfg_data;
        mfc_pkg::REG_SIZE_3:      cfg.size_3      <= cfg_data;
        mfc_pkg::REG_SIZE_4:      cfg.size_4      <= cfg_data;
        mfc_pkg::REG_ACT_MODE:    cfg.act_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  mfc_wmem u_wmem (
    .clk   (clk),
    .we    (in_fire && in_data.req_type == mfc_pkg::REQ_WEIGHT),
    .waddr (mfc_pkg::WADDR_W'(in_data.position)),
    .wdata (in_data.data_value),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  mfc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .smp_we    (in_fire && in_data.req_type == mfc_pkg::REQ_SAMPLE),
    .smp_pos   (in_data.position),
    .smp_val   (in_data.data_value),
    .start     (in_fire && in_data.req_type == mfc_pkg::REQ_SAMPLE && in_data.final_element),
    .busy      (busy),
    .w_raddr   (w_raddr),
    .w_rdata   (w_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/mfc_wmem.sv
// weight memory, one write port and one registered read port
// depends on mfc_pkg
module mfc_wmem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [mfc_pkg::WADDR_W-1:0]   waddr,
  input  logic signed [15:0]            wdata,
  input  logic [mfc_pkg::WADDR_W-1:0]   raddr,
  output logic signed [15:0]            rdata
);

  logic signed [15:0] mem [mfc_pkg::WEIGHT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/mfc_vmem.sv
// layer value memory, two banks of bias plus neuron outputs
// depends on mfc_pkg
module mfc_vmem (
  input  logic                  clk,
  input  mfc_pkg::vmem_req_t    req,
  output logic signed [15:0]    rdata
);

  logic signed [15:0] mem [2][mfc_pkg::MAX_WIDTH + 1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wbank][req.widx] <= req.wdata;
    end
    rdata <= mem[req.rbank][req.ridx];
  end

endmodule

// File: rtl/core/mfc_engine.sv
// layer sequencer: sample buffer, multiply-accumulate pipe, activation, argmax, result register
// depends on mfc_pkg, mfc_wmem read port, mfc_vmem
module mfc_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  mfc_pkg::cfg_t                 cfg,
  input  logic                          smp_we,
  input  logic [10:0]                   smp_pos,
  input  logic signed [15:0]            smp_val,
  input  logic                          start,
  output logic                          busy,
  output logic [mfc_pkg::WADDR_W-1:0]   w_raddr,
  input  logic signed [15:0]            w_rdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mfc_pkg::out_beat_t            out_data
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LSTART = 7'b0000010,
    ST_ISSUE  = 7'b0000100,
    ST_DRAIN  = 7'b0001000,
    ST_FIN    = 7'b0010000,
    ST_OREAD  = 7'b0100000,
    ST_OWAIT  = 7'b1000000
  } state_t;

  localparam mfc_pkg::tab_t LOGI_TAB = mfc_pkg::build_tab(1'b0);
  localparam mfc_pkg::tab_t TANH_TAB = mfc_pkg::build_tab(1'b1);

  state_t state;
  logic signed [15:0] sbuf [mfc_pkg::MAX_WIDTH + 1];
  logic signed [15:0] smp_q;
  logic signed [15:0] v_rdata;
  mfc_pkg::vmem_req_t vreq;

  logic [mfc_pkg::LAYER_W-1:0] layer;
  logic [3:0]                  neuron;
  logic [mfc_pkg::VIDX_W-1:0]  jidx;
  logic [mfc_pkg::VIDX_W-1:0]  curlen;
  logic [4:0]                  lsize;
  logic [mfc_pkg::WADDR_W-1:0] wptr;
  logic                        wbank;
  logic                        rbank;
  logic [3:0]                  oidx;

  logic                        s1_vld, s1_first, s1_last, s1_src;
  logic                        s2_vld, s2_first, s2_last;
  logic signed [31:0]          prod;
  logic signed [mfc_pkg::ACC_W-1:0] acc;
  logic                        sum_rdy;

  logic [3:0]                  best_idx;
  logic signed [15:0]          best_val;

  logic signed [mfc_pkg::ACC_W-1:0] rnd;
  logic signed [15:0]          sum16;
  logic signed [11:0]          clip;
  logic [11:0]                 offs;
  logic [mfc_pkg::TIDX_W-1:0]  tidx;
  logic signed [15:0]          act;
  logic [2:0]                  nl;
  logic                        last_layer;
  logic                        last_neuron;
  logic [4:0]                  next_size;
  logic signed [15:0]          operand;

  assign busy = (state != ST_IDLE);

  always_comb begin
    nl = cfg.layer_count;
    if (nl == 3'd0) nl = 3'd1;
    if (nl > 3'(mfc_pkg::MAX_LAYERS)) nl = 3'(mfc_pkg::MAX_LAYERS);
  end

  assign last_layer  = ({1'b0, layer} + 3'd1) == nl;
  assign last_neuron = {1'b0, neuron} == (lsize - 5'd1);

  always_comb begin
    case (layer)
      2'd0:    next_size = mfc_pkg::clamp_size(cfg.size_2);
      2'd1:    next_size = mfc_pkg::clamp_size(cfg.size_3);
      2'd2:    next_size = mfc_pkg::clamp_size(cfg.size_4);
      default: next_size = 5'd1;
    endcase
  end

  // round half up, saturate, activate (other act modes pass the sum through)
  always_comb begin
    rnd = acc + mfc_pkg::ACC_W'(128);
    if (rnd >= mfc_pkg::ACC_W'(32768 * 256)) begin
      sum16 = 16'sd32767;
    end else if (rnd < -mfc_pkg::ACC_W'(32768 * 256)) begin
      sum16 = -16'sd32768;
    end else begin
      sum16 = 16'(rnd >>> 8);
    end
    if (sum16 < -16'sd2048) begin
      clip = -12'sd2048;
    end else if (sum16 > 16'sd2047) begin
      clip = 12'sd2047;
    end else begin
      clip = 12'(sum16);
    end
    offs = {~clip[11], clip[10:0]};
    tidx = offs[11:12-mfc_pkg::TIDX_W];
    case (cfg.act_mode)
      mfc_pkg::ACT_LOGISTIC: act = LOGI_TAB[tidx];
      mfc_pkg::ACT_TANH:     act = TANH_TAB[tidx];
      default:               act = sum16;
    endcase
  end

  always_comb begin
    vreq.we    = 1'b0;
    vreq.wbank = wbank;
    vreq.widx  = '0;
    vreq.wdata = act;
    vreq.rbank = rbank;
    vreq.ridx  = jidx;
    if (state == ST_LSTART) begin
      vreq.we    = 1'b1;
      vreq.wdata = mfc_pkg::BIAS_NEG_ONE;
    end else if (state == ST_FIN) begin
      vreq.we   = 1'b1;
      vreq.widx = last_layer ? mfc_pkg::VIDX_W'(neuron)
                             : mfc_pkg::VIDX_W'({1'b0, neuron} + 5'd1);
    end
    if (state == ST_OREAD) begin
      vreq.rbank = wbank;
      vreq.ridx  = mfc_pkg::VIDX_W'(oidx);
    end
  end

  assign w_raddr = wptr;

  mfc_vmem u_vmem (
    .clk   (clk),
    .req   (vreq),
    .rdata (v_rdata)
  );

  // sample buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= mfc_pkg::MAX_WIDTH; i++) begin
        sbuf[i] <= '0;
      end
    end else if (smp_we && smp_pos <= 11'(mfc_pkg::MAX_WIDTH)) begin
      sbuf[mfc_pkg::VIDX_W'(smp_pos)] <= smp_val;
    end
  end

  assign operand = s1_src ? smp_q : v_rdata;

  // multiply-accumulate pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      sum_rdy <= 1'b0;
    end else begin
      s1_vld <= (state == ST_ISSUE);
      s2_vld <= s1_vld;
      if (s2_vld && s2_last) begin
        sum_rdy <= 1'b1;
      end else if (state == ST_FIN) begin
        sum_rdy <= 1'b0;
      end
    end
    smp_q    <= sbuf[jidx];
    s1_first <= (jidx == '0);
    s1_last  <= (jidx == curlen - 1'b1);
    s1_src   <= (layer == '0);
    prod     <= w_rdata * operand;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    if (s2_vld) begin
      acc <= s2_first ? mfc_pkg::ACC_W'(prod) : acc + mfc_pkg::ACC_W'(prod);
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      best_idx  <= '0;
      best_val  <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            layer  <= '0;
            neuron <= '0;
            jidx   <= '0;
            wptr   <= '0;
            wbank  <= 1'b0;
            rbank  <= 1'b1;
            curlen <= mfc_pkg::clamp_size(cfg.input_count) + 5'd1;
            lsize  <= mfc_pkg::clamp_size(cfg.size_1);
            state  <= ST_LSTART;
          end
        end
        ST_LSTART: begin
          jidx  <= '0;
          state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          wptr <= wptr + 1'b1;
          jidx <= jidx + 1'b1;
          if (jidx == curlen - 1'b1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (sum_rdy) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (last_layer && (neuron == '0 || act > best_val)) begin
            best_idx <= neuron;
            best_val <= act;
          end
          jidx <= '0;
          if (!last_neuron) begin
            neuron <= neuron + 1'b1;
            state  <= ST_ISSUE;
          end else if (last_layer) begin
            oidx  <= '0;
            state <= ST_OREAD;
          end else begin
            neuron <= '0;
            layer  <= layer + 1'b1;
            curlen <= lsize + 5'd1;
            lsize  <= next_size;
            rbank  <= wbank;
            wbank  <= ~wbank;
            state  <= ST_LSTART;
          end
        end
        ST_OREAD: begin
          if (!out_valid || !out_stall) begin
            state <= ST_OWAIT;
          end
        end
        ST_OWAIT: begin
          out_valid             <= 1'b1;
          out_data.neuron_index <= oidx;
          out_data.neuron_value <= v_rdata;
          out_data.last_output  <= ({1'b0, oidx} == lsize - 5'd1);
          out_data.best_class   <= ({1'b0, oidx} == lsize - 5'd1) ? best_idx : 4'd0;
          if ({1'b0, oidx} == lsize - 5'd1) begin
            state <= ST_IDLE;
          end else begin
            oidx  <= oidx + 1'b1;
            state <= ST_OREAD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_issue_src: assert property (@(posedge clk) disable iff (rst)
    s1_vld |-> $past(state) == ST_ISSUE)
    else $error("mac beat without issue");
  a_fin_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> !s1_vld && !s2_vld)
    else $error("finalize with mac pipe busy");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_OWAIT |-> !out_valid)
    else $error("result register overwritten");
  a_idle_start: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("start while busy");

endmodule

// File: dv/mlp_forward_classifier_top_tb.sv
// testbench for mlp_forward_classifier_top: loads weights and samples, predicts each
// output neuron and the argmax class with its own fixed-point network, checks every beat
// depends on mfc_pkg and mlp_forward_classifier_top
`timescale 1ns / 100ps

class neuron_scoreboard;
  mfc_pkg::out_beat_t pending[$];
  int errors;

  function void report_error(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endfunction

  function void note_input(mfc_pkg::out_beat_t b);
    pending.push_back(b);
  endfunction

  function void check_result(mfc_pkg::out_beat_t got);
    mfc_pkg::out_beat_t exp_b;
    if (pending.size() == 0) begin
      report_error($sformatf("unexpected result idx %0d", got.neuron_index));
      return;
    end
    exp_b = pending.pop_front();
    if (got.neuron_index !== exp_b.neuron_index)
      report_error($sformatf("neuron_index %0d exp %0d", got.neuron_index, exp_b.neuron_index));
    if (got.neuron_value !== exp_b.neuron_value)
      report_error($sformatf("neuron_value %0d exp %0d (idx %0d)", got.neuron_value,
                             exp_b.neuron_value, exp_b.neuron_index));
    if (got.best_class !== exp_b.best_class)
      report_error($sformatf("best_class %0d exp %0d", got.best_class, exp_b.best_class));
    if (got.last_output !== exp_b.last_output)
      report_error($sformatf("last_output %0d exp %0d", got.last_output, exp_b.last_output));
  endfunction
endclass

module mlp_forward_classifier_top_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mfc_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mfc_pkg::out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  mlp_forward_classifier_top u_top (.*);

  always #5 clk = ~clk;

  neuron_scoreboard sb = new();

  logic [15:0] weights [mfc_pkg::WEIGHT_DEPTH];
  logic signed [15:0] samples [mfc_pkg::MAX_WIDTH + 1];
  logic [4:0] regs [7];
  mfc_pkg::tab_t logistic_tab, tanh_tab;
  int send_idle_pct, stall_pct;
  int idle_cycles;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    if (!rst) out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int eff_size(logic [4:0] v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic signed [15:0] activated(logic signed [15:0] x);
    int c, idx;
    if (regs[mfc_pkg::REG_ACT_MODE] != mfc_pkg::ACT_LOGISTIC &&
        regs[mfc_pkg::REG_ACT_MODE] != mfc_pkg::ACT_TANH) return x;
    c = (x < -2048) ? -2048 : ((x > 2047) ? 2047 : x);
    idx = ((c + 2048) * mfc_pkg::TABLE_SIZE) >> 12;
    if (idx >= mfc_pkg::TABLE_SIZE) idx = mfc_pkg::TABLE_SIZE - 1;
    return (regs[mfc_pkg::REG_ACT_MODE] == mfc_pkg::ACT_LOGISTIC) ? logistic_tab[idx]
                                                                  : tanh_tab[idx];
  endfunction

  function automatic logic signed [15:0] rounded_sum(longint acc);
    longint r;
    r = acc + 128;
    if (r >= 32768 * 256) return 16'sd32767;
    if (r < -32768 * 256) return -16'sd32768;
    return 16'(r >>> 8);
  endfunction

  // runs the network on the stored sample and queues one beat per output neuron
  function automatic void predict_outputs();
    logic signed [15:0] vals [mfc_pkg::MAX_WIDTH + 1];
    logic signed [15:0] sums [mfc_pkg::MAX_WIDTH];
    int inn, nl, s, curlen, base, best;
    longint acc;
    mfc_pkg::out_beat_t b;
    inn = eff_size(regs[mfc_pkg::REG_INPUT_COUNT], mfc_pkg::MAX_WIDTH);
    nl = eff_size({2'b0, regs[mfc_pkg::REG_LAYER_COUNT][2:0]}, mfc_pkg::MAX_LAYERS);
    for (int i = 0; i <= inn; i++) vals[i] = samples[i];
    curlen = inn + 1;
    base = 0;
    for (int l = 0; l < nl; l++) begin
      s = eff_size(regs[mfc_pkg::REG_SIZE_1 + l], mfc_pkg::MAX_WIDTH);
      for (int i = 0; i < s; i++) begin
        acc = 0;
        for (int j = 0; j < curlen; j++)
          acc += longint'($signed(weights[(base + i * curlen + j) % mfc_pkg::WEIGHT_DEPTH]))
                 * longint'(vals[j]);
        sums[i] = rounded_sum(acc);
      end
      base += s * curlen;
      if (l + 1 == nl) begin
        for (int i = 0; i < s; i++) vals[i] = activated(sums[i]);
      end else begin
        vals[0] = mfc_pkg::BIAS_NEG_ONE;
        for (int i = 0; i < s; i++) vals[i + 1] = activated(sums[i]);
        curlen = s + 1;
      end
    end
    best = 0;
    for (int i = 1; i < s; i++) if (vals[i] > vals[best]) best = i;
    for (int i = 0; i < s; i++) begin
      b.neuron_index = 4'(i);
      b.neuron_value = vals[i];
      b.last_output = (i + 1 == s);
      b.best_class = b.last_output ? 4'(best) : 4'd0;
      sb.note_input(b);
    end
  endfunction

  // valid stays high after the beat until the next beat replaces it or an idle cycle or drain drops it
  task automatic send_beat(logic rq, logic [10:0] pos, logic signed [15:0] val, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: rq, position: pos, data_value: val, final_element: fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (rq == mfc_pkg::REQ_WEIGHT) begin
      if (pos < mfc_pkg::WEIGHT_DEPTH) weights[pos] = val;
    end else begin
      if (pos <= mfc_pkg::MAX_WIDTH) samples[pos] = val;
      if (fin) predict_outputs();
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    regs[idx] = val & ((idx == mfc_pkg::REG_LAYER_COUNT) ? 5'd7 :
                       (idx == mfc_pkg::REG_ACT_MODE ? 5'd3 : 5'd31));
  endtask

  function automatic int weights_needed();
    int inn, nl, curlen, total, s;
    inn = eff_size(regs[mfc_pkg::REG_INPUT_COUNT], mfc_pkg::MAX_WIDTH);
    nl = eff_size({2'b0, regs[mfc_pkg::REG_LAYER_COUNT][2:0]}, mfc_pkg::MAX_LAYERS);
    curlen = inn + 1;
    total = 0;
    for (int l = 0; l < nl; l++) begin
      s = eff_size(regs[mfc_pkg::REG_SIZE_1 + l], mfc_pkg::MAX_WIDTH);
      total += s * curlen;
      curlen = s + 1;
    end
    return total;
  endfunction

  function automatic logic signed [15:0] rand_val(int mag);
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(2 * mag)) - mag);
    endcase
  endfunction

  // fills every weight the network reads, then one or more samples
  task automatic run_network(int nsamples, int mag);
    int nw, inn;
    nw = weights_needed();
    for (int a = 0; a < nw && a < mfc_pkg::WEIGHT_DEPTH; a++)
      send_beat(mfc_pkg::REQ_WEIGHT, 11'(a), rand_val(mag), $urandom_range(1));
    inn = eff_size(regs[mfc_pkg::REG_INPUT_COUNT], mfc_pkg::MAX_WIDTH);
    for (int k = 0; k < nsamples; k++) begin
      for (int e = 0; e < inn; e++)
        if ($urandom_range(5) != 0)
          send_beat(mfc_pkg::REQ_SAMPLE, 11'(e), rand_val(mag), 1'b0);
      if ($urandom_range(7) == 0)
        send_beat(mfc_pkg::REQ_SAMPLE, 11'($urandom_range(2047, 17)), rand_val(mag), 1'b0);
      send_beat(mfc_pkg::REQ_SAMPLE, 11'(inn), rand_val(mag), 1'b1);
    end
  endtask

  task automatic configure(int ic, int lc, int s1, int s2, int s3, int s4, int am);
    write_reg(mfc_pkg::REG_INPUT_COUNT, 5'(ic));
    write_reg(mfc_pkg::REG_LAYER_COUNT, 5'(lc));
    write_reg(mfc_pkg::REG_SIZE_1, 5'(s1));
    write_reg(mfc_pkg::REG_SIZE_2, 5'(s2));
    write_reg(mfc_pkg::REG_SIZE_3, 5'(s3));
    write_reg(mfc_pkg::REG_SIZE_4, 5'(s4));
    write_reg(mfc_pkg::REG_ACT_MODE, 5'(am));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int beats_sent;
    logistic_tab = mfc_pkg::build_tab(1'b0);
    tanh_tab = mfc_pkg::build_tab(1'b1);
    regs = '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd0};
    for (int i = 0; i <= mfc_pkg::MAX_WIDTH; i++) samples[i] = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset config, extremes, final flag on a weight write, bad positions
    send_beat(mfc_pkg::REQ_WEIGHT, 11'd0, 16'sh7fff, 1'b1);
    send_beat(mfc_pkg::REQ_WEIGHT, 11'd1, -16'sd32768, 1'b0);
    send_beat(mfc_pkg::REQ_WEIGHT, 11'd2047, 16'sd256, 1'b0);
    send_beat(mfc_pkg::REQ_SAMPLE, 11'd0, 16'sh7fff, 1'b0);
    send_beat(mfc_pkg::REQ_SAMPLE, 11'd1, -16'sd32768, 1'b1);
    send_beat(mfc_pkg::REQ_SAMPLE, 11'd2047, 16'sd5, 1'b1);
    send_beat(mfc_pkg::REQ_SAMPLE, 11'd16, -16'sd1, 1'b0);
    drain();
    configure(0, 0, 0, 0, 0, 0, 1);
    run_network(2, 300);
    drain();
    configure(31, 7, 1, 1, 1, 31, 3);
    run_network(1, 40);
    drain();
    configure(2, 2, 3, 4, 0, 0, 2);
    run_network(2, 400);
    drain();

    beats_sent = 0;
    for (int ph = 0; beats_sent < 350; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      configure($urandom_range(6, 1), $urandom_range(4, 1), $urandom_range(6, 1),
                $urandom_range(6, 1), $urandom_range(4, 1), $urandom_range(16, 1),
                $urandom_range(3));
      beats_sent += weights_needed() +
                    4 * (eff_size(regs[mfc_pkg::REG_INPUT_COUNT], 16) + 1);
      run_network(4, $urandom_range(1) ? 600 : 4000);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
